### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the percent decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");
// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

### hw/rtl/lpd_pkg.sv
// Package: types, constants and hex helpers of the lenient percent decoder.
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

  localparam logic [7:0]  PCT_CHAR   = 8'h25;
  localparam logic [15:0] LIMIT_RST  = 16'd255;
  localparam int          JOB_BYTES  = 3;

  // Escape phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_terminator;
    logic       last_in_run;
  } out_word_t;

  // One input word's worth of work: up to three data bytes and a terminator
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] data;
    logic [1:0]                num;
    logic                      term;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    hex_val = v[3:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lpd_front.sv
// Front end: escape tracking and building of the per-word job.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lpd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire lpd_pkg::in_word_t in_word,
  input  wire lpd_pkg::q_status_t q_status,
  output lpd_pkg::job_t         job,
  output logic                  job_valid
);

  logic [1:0] phase, phase_next;
  logic [7:0] held, held_next;
  logic       accept;
  logic       do_plain;
  logic [7:0] b;

  assign accept = in_valid && !q_status.full;
  assign b      = in_word.in_byte;

  // Job build and next escape state
  always_comb begin
    job        = '0;
    phase_next = lpd_pkg::PH_IDLE;
    held_next  = held;
    do_plain   = 1'b0;
    unique case (phase)
      lpd_pkg::PH_PCT: begin
        if (lpd_pkg::hex_ok(b)) begin
          held_next  = b;
          phase_next = lpd_pkg::PH_DIGIT;
        end else begin
          job.data[job.num] = lpd_pkg::PCT_CHAR;
          job.num           = job.num + 2'd1;
          do_plain          = 1'b1;
        end
      end
      lpd_pkg::PH_DIGIT: begin
        if (lpd_pkg::hex_ok(b) && lpd_pkg::hex_ok(held)) begin
          job.data[job.num] = {lpd_pkg::hex_val(held), lpd_pkg::hex_val(b)};
          job.num           = job.num + 2'd1;
        end else begin
          job.data[job.num] = lpd_pkg::PCT_CHAR;
          job.num           = job.num + 2'd1;
          job.data[job.num] = held;
          job.num           = job.num + 2'd1;
          do_plain          = 1'b1;
        end
        held_next = 8'd0;
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
    // normal rule for a byte with nothing held
    if (do_plain) begin
      if (b == lpd_pkg::PCT_CHAR) begin
        phase_next = lpd_pkg::PH_PCT;
      end else begin
        phase_next        = lpd_pkg::PH_IDLE;
        job.data[job.num] = b;
        job.num           = job.num + 2'd1;
      end
    end
    // end of text: flush what is held, then terminate
    if (in_word.final_byte) begin
      if (phase_next == lpd_pkg::PH_PCT) begin
        job.data[job.num] = lpd_pkg::PCT_CHAR;
        job.num           = job.num + 2'd1;
      end else if (phase_next == lpd_pkg::PH_DIGIT) begin
        job.data[job.num] = lpd_pkg::PCT_CHAR;
        job.num           = job.num + 2'd1;
        job.data[job.num] = held_next;
        job.num           = job.num + 2'd1;
      end
      job.term   = 1'b1;
      phase_next = lpd_pkg::PH_IDLE;
      held_next  = 8'd0;
    end
  end

  assign job_valid = accept && (job.term || job.num != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lpd_pkg::PH_IDLE;
      held  <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  // A final word always leaves the front with nothing held
  `ASSERT_PROP(a_fin_clears, clk, rst,
    (accept && in_word.final_byte) |=> (phase == lpd_pkg::PH_IDLE && held == 8'd0))
  // A final word always produces a job
  `ASSERT_PROP(a_fin_job, clk, rst, (accept && in_word.final_byte) |-> job_valid)

endmodule
`default_nettype wire

### hw/rtl/lpd_queue.sv
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lpd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lpd_pkg::job_t  push_job,
  input  wire logic           pop,
  output lpd_pkg::job_t       head,
  output lpd_pkg::q_status_t  q_status
);

  lpd_pkg::job_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          do_push, do_pop;

  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, count == 2'd3)
  `ASSERT_PROP(a_ptr_gap, clk, rst,
    (q_status.empty || q_status.full) |-> (wr_ptr == rd_ptr))

endmodule
`default_nettype wire

### hw/rtl/lpd_back.sv
// Back end: serialises jobs into result words, applies the length limit.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lpd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lpd_pkg::job_t      head,
  input  wire lpd_pkg::q_status_t q_status,
  input  wire logic [15:0]        limit,
  output logic                    pop,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output lpd_pkg::out_word_t      out_word
);

  logic [1:0]         idx, idx_next;
  logic [15:0]        count, count_next;
  logic               slot_free;
  logic               has_data, can_emit, step;
  logic               load;
  lpd_pkg::out_word_t word_next;
  logic [16:0]        count_inc;

  assign slot_free = !out_valid || !out_stall;
  assign step      = slot_free && !q_status.empty;
  assign has_data  = idx < head.num;
  assign can_emit  = count < limit;
  assign count_inc = {1'b0, count} + 17'd1;

  // Pick the next result of the head job
  always_comb begin
    word_next  = '0;
    load       = 1'b0;
    pop        = 1'b0;
    idx_next   = idx;
    count_next = count;
    if (step) begin
      if (has_data && can_emit) begin
        load               = 1'b1;
        word_next.out_byte = head.data[idx];
        count_next         = count_inc[15:0];
        // nothing further of this job will go out
        if (!head.term && ((idx + 2'd1 == head.num) || count_inc >= {1'b0, limit})) begin
          word_next.last_in_run = 1'b1;
          pop                   = 1'b1;
          idx_next              = 2'd0;
        end else begin
          idx_next = idx + 2'd1;
        end
      end else if (head.term) begin
        load                    = 1'b1;
        word_next.is_terminator = 1'b1;
        word_next.last_in_run   = 1'b1;
        count_next              = 16'd0;
        pop                     = 1'b1;
        idx_next                = 2'd0;
      end else begin
        // every byte of this job is past the limit
        pop      = 1'b1;
        idx_next = 2'd0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      count     <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      idx   <= idx_next;
      count <= count_next;
      if (slot_free) out_valid <= load;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      out_word <= word_next;
    end
  end

  `ASSERT_PROP(a_term_word, clk, rst,
    (out_valid && out_word.is_terminator) |->
      (out_word.last_in_run && out_word.out_byte == 8'd0))
  `ASSERT_PROP(a_term_resets, clk, rst,
    (load && word_next.is_terminator) |=> (count == 16'd0 && idx == 2'd0))

endmodule
`default_nettype wire

### hw/rtl/lenient_percent_decoder_core.sv
// Top level of the lenient percent decoder: limit register and the three stages.
`timescale 1ns / 1ps
`default_nettype none
// Streaming percent decoder. Each input word is one byte of a text, with a flag
// on the last byte; '%' plus two hex digits (either case) becomes one byte, and
// anything that is not a valid escape passes through. Each text ends in one
// terminator word. The front end takes one input word per cycle while its
// two-entry job queue has room; the back end sends out one result word per
// cycle while out_stall is low, so a word with several results (up to four)
// holds the back end until all are out; a non-final word whose bytes all fall
// past max_output_length is popped with no result. Sustained rate is one input
// word per cycle while words cause at most one result each and out_stall is
// low. The limit register is written through cfg_write/cfg_data and resets to 255.
module lenient_percent_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lpd_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lpd_pkg::out_word_t      out_word,
  input  wire logic               cfg_write,
  input  wire logic [15:0]        cfg_data
);

  logic [15:0]        max_output_length;
  lpd_pkg::job_t      job, head;
  logic               job_valid, pop;
  lpd_pkg::q_status_t q_status;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_length <= lpd_pkg::LIMIT_RST;
    end else if (cfg_write) begin
      max_output_length <= cfg_data;
    end
  end

  assign in_stall = q_status.full;

  lpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_status (q_status),
    .job      (job),
    .job_valid(job_valid)
  );

  lpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_valid),
    .push_job(job),
    .pop     (pop),
    .head    (head),
    .q_status(q_status)
  );

  lpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .limit    (max_output_length),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

### sim/tb_lenient_percent_decoder_core.sv
// Self-checking testbench for the lenient percent decoder core.
`timescale 1ns / 1ps
module tb_lenient_percent_decoder_core;

  typedef logic [7:0] text_q_t[$];

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 12;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lpd_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lpd_pkg::out_word_t out_word;
  logic               cfg_write = 1'b0;
  logic [15:0]        cfg_data = '0;

  // Predictor state and the decoded words still owed by the block
  logic [1:0]         esc_phase;
  logic [7:0]         held_digit;
  logic [15:0]        data_count;
  logic [15:0]        limit_reg;
  lpd_pkg::out_word_t burst[$];
  lpd_pkg::out_word_t owed_words[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  lenient_percent_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hex digit classification, either case
  function automatic logic is_hex_char(input logic [7:0] c);
    case (c) inside
      ["0":"9"], ["a":"f"], ["A":"F"]: return 1'b1;
      default:                         return 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c <= "9") return 4'(c - "0");
    else if (c >= "a") return 4'(c - "a" + 8'd10);
    else return 4'(c - "A" + 8'd10);
  endfunction

  // Data byte goes out only while the text is under the limit
  function automatic void push_data(input logic [7:0] b);
    lpd_pkg::out_word_t w;
    if (data_count < limit_reg) begin
      w.out_byte      = b;
      w.is_terminator = 1'b0;
      w.last_in_run   = 1'b0;
      burst.push_back(w);
      data_count++;
    end
  endfunction

  function automatic void take_plain(input logic [7:0] b);
    if (b == lpd_pkg::PCT_CHAR) begin
      esc_phase = lpd_pkg::PH_PCT;
    end else begin
      esc_phase = lpd_pkg::PH_IDLE;
      push_data(b);
    end
  endfunction

  // Works out the words that one accepted input word causes
  function automatic void decode_byte(input lpd_pkg::in_word_t w);
    lpd_pkg::out_word_t t;
    burst.delete();
    case (esc_phase)
      lpd_pkg::PH_PCT: begin
        if (is_hex_char(w.in_byte)) begin
          held_digit = w.in_byte;
          esc_phase  = lpd_pkg::PH_DIGIT;
        end else begin
          push_data(lpd_pkg::PCT_CHAR);
          esc_phase = lpd_pkg::PH_IDLE;
          take_plain(w.in_byte);
        end
      end
      lpd_pkg::PH_DIGIT: begin
        if (is_hex_char(w.in_byte) && is_hex_char(held_digit)) begin
          push_data({nibble_of(held_digit), nibble_of(w.in_byte)});
          esc_phase = lpd_pkg::PH_IDLE;
        end else begin
          push_data(lpd_pkg::PCT_CHAR);
          push_data(held_digit);
          esc_phase = lpd_pkg::PH_IDLE;
          take_plain(w.in_byte);
        end
        held_digit = '0;
      end
      default: begin
        esc_phase = lpd_pkg::PH_IDLE;
        take_plain(w.in_byte);
      end
    endcase
    // End of text: flush any held escape raw, then the terminator
    if (w.final_byte) begin
      if (esc_phase == lpd_pkg::PH_PCT) begin
        push_data(lpd_pkg::PCT_CHAR);
      end else if (esc_phase == lpd_pkg::PH_DIGIT) begin
        push_data(lpd_pkg::PCT_CHAR);
        push_data(held_digit);
      end
      t.out_byte      = '0;
      t.is_terminator = 1'b1;
      t.last_in_run   = 1'b0;
      burst.push_back(t);
      esc_phase  = lpd_pkg::PH_IDLE;
      held_digit = '0;
      data_count = '0;
    end
    if (burst.size() > 0) burst[burst.size()-1].last_in_run = 1'b1;
    foreach (burst[i]) owed_words.push_back(burst[i]);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (rst) begin
      esc_phase  = lpd_pkg::PH_IDLE;
      held_digit = '0;
      data_count = '0;
      limit_reg  = lpd_pkg::LIMIT_RST;
    end else if (in_valid && !in_stall) begin
      decode_byte(in_word);
    end
  end

  // Compare every accepted output word with the oldest one owed
  always @(posedge clk) begin
    lpd_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        report_error($sformatf("unexpected word byte=%h term=%b last=%b",
                     out_word.out_byte, out_word.is_terminator, out_word.last_in_run));
      end else begin
        want = owed_words.pop_front();
        if (out_word.out_byte !== want.out_byte)
          report_error($sformatf("out_byte %h, expected %h",
                       out_word.out_byte, want.out_byte));
        if (out_word.is_terminator !== want.is_terminator)
          report_error($sformatf("is_terminator %b, expected %b",
                       out_word.is_terminator, want.is_terminator));
        if (out_word.last_in_run !== want.last_in_run)
          report_error($sformatf("last_in_run %b, expected %b",
                       out_word.last_in_run, want.last_in_run));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (rx_idle_pct > 0) && ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Watchdog expired at %0t", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one word and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_word.in_byte    <= b;
    in_word.final_byte <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input text_q_t txt, input logic fin_last);
    foreach (txt[i]) send_word(txt[i], fin_last && (i == txt.size() - 1));
  endtask

  // Wait for every owed word, then let the back end settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    limit_reg = v;
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  // Text of random tokens: plain bytes, good and broken escapes, noise
  function automatic text_q_t random_text();
    text_q_t txt;
    int n_tok;
    logic [7:0] c;
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          c = 8'($urandom_range(32, 126));
          txt.push_back(c == lpd_pkg::PCT_CHAR ? "x" : c);
        end
        3, 4, 5: begin
          txt.push_back(lpd_pkg::PCT_CHAR);
          txt.push_back(rand_hex_char());
          txt.push_back(rand_hex_char());
        end
        6: begin
          txt.push_back(lpd_pkg::PCT_CHAR);
          txt.push_back(8'($urandom_range(0, 255)));
        end
        7: begin
          txt.push_back(lpd_pkg::PCT_CHAR);
          txt.push_back(rand_hex_char());
          txt.push_back(8'($urandom_range(0, 255)));
        end
        8:       txt.push_back(lpd_pkg::PCT_CHAR);
        default: txt.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    return txt;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 6));
      4:       return lpd_pkg::LIMIT_RST;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Byte extremes, upper and lower case escapes
  task automatic test_valid_escapes();
    send_text('{8'h00, 8'hFF, lpd_pkg::PCT_CHAR, "4", "1",
                lpd_pkg::PCT_CHAR, "f", "F"}, 1'b1);
    send_word("x", 1'b1);
  endtask

  // Failed escapes, a new escape opened by a held '%', flushes at end of text
  task automatic test_broken_escapes();
    send_text('{lpd_pkg::PCT_CHAR, "G", lpd_pkg::PCT_CHAR, "4",
                lpd_pkg::PCT_CHAR, "4", "1", lpd_pkg::PCT_CHAR}, 1'b1);
    send_text('{lpd_pkg::PCT_CHAR, "a"}, 1'b1);
  endtask

  // Bytes past the limit are dropped, terminator still sent; limit moved mid-text
  task automatic test_output_limit();
    wait_idle();
    write_limit(16'd2);
    send_text('{"a", "b", lpd_pkg::PCT_CHAR, "4", "1"}, 1'b1);
    wait_idle();
    write_limit(16'd1);
    send_text('{"a", "b"}, 1'b0);
    wait_idle();
    write_limit(16'd3);
    send_word("c", 1'b1);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [15:0] first_limit, input int n_items);
    int sent;
    int texts;
    text_q_t txt;
    sent  = 0;
    texts = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < n_items) begin
      if (texts % 5 == 0) begin
        wait_idle();
        write_limit(texts == 0 ? first_limit : pick_limit());
      end
      txt = random_text();
      send_text(txt, 1'b1);
      sent += txt.size();
      texts++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_valid_escapes();
    test_broken_escapes();
    test_output_limit();
    test_random_traffic(11, 57, 16'hFFFF, 100);
    test_random_traffic(57, 11, 16'h0000, 100);
    test_random_traffic(0, 0, lpd_pkg::LIMIT_RST, 100);
    wait_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
